// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion lbl failed");

// The expression must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion lbl failed");

`endif

// ----- hdl/ilu_pkg.sv -----
// Package with the constants, types and arithmetic helpers of the upscaler.
`default_nettype none
package ilu_pkg;

  localparam int unsigned SCREEN_W      = 240;
  localparam int unsigned SCREEN_H      = 240;
  localparam int unsigned MAX_IMAGE_DIM = 256;
  localparam int unsigned DIM_W         = 9;
  localparam int unsigned SIZE_W        = 2 * DIM_W;
  localparam int unsigned CANVAS_DEPTH  = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int unsigned CANVAS_AW     = $clog2(CANVAS_DEPTH);
  localparam int unsigned PAL_DEPTH     = 256;
  localparam int unsigned COLOR_W       = 16;
  localparam int unsigned NUM_W         = 16;
  localparam int unsigned QUO_W         = 8;
  localparam int unsigned S_TDATA_W     = 40;
  localparam int unsigned M_TDATA_W     = 56;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH       = 3'd0,
    CFG_IMAGE_HEIGHT      = 3'd1,
    CFG_FRAME_TOP         = 3'd2,
    CFG_RESTORE_MODE      = 3'd3,
    CFG_TRANSPARENT_INDEX = 3'd4,
    CFG_BACKGROUND_INDEX  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_PIXEL   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic             qbit;
  } div_step_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_IMAGE_DIM)) r = DIM_W'(MAX_IMAGE_DIM);
    return r;
  endfunction

  // One restoring division step for quotient bit sh.
  function automatic div_step_t div_step(input logic [NUM_W-1:0] rem,
                                         input logic [DIM_W-1:0] d,
                                         input int unsigned sh);
    logic [NUM_W+DIM_W-1:0] dsh;
    div_step_t r;
    dsh = (NUM_W+DIM_W)'(d) << sh;
    if ((NUM_W+DIM_W)'(rem) >= dsh) begin
      r.rem  = NUM_W'((NUM_W+DIM_W)'(rem) - dsh);
      r.qbit = 1'b1;
    end else begin
      r.rem  = rem;
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/indexed_line_upscale_dirty_rect.sv -----
// Top level: palette and dirty-canvas lookup followed by a pipelined upscale divider.
// A pixel word passes the palette and canvas lookup registers, then the divider stages.
// Throughput is one word per cycle while the output is not stalled and no clear runs.
// A pixel word whose image size product differs from the last one first waits for a
// clearing pass over all 65536 canvas entries, one entry per cycle; after reset the
// first pixel word always starts that pass. Reset is asynchronous and active low.
`default_nettype none
module indexed_line_upscale_dirty_rect (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [ilu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ilu_pkg::DIM_W-1:0]        cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // column[7:0], row[15:8], pixel_index[23:16], palette_color[39:24]
  input  wire logic [ilu_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // command[0]
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // rect_x[7:0], rect_y[16:8], rect_width[24:17], rect_height[32:25],
  // fill_color[48:33], zero[55:49]
  output logic [ilu_pkg::M_TDATA_W-1:0]         m_axis_tdata
);

  localparam int unsigned QB = ilu_pkg::QUO_W;
  localparam int unsigned AW = ilu_pkg::CANVAS_AW;
  localparam int unsigned CW = ilu_pkg::COLOR_W;
  localparam int unsigned NW = ilu_pkg::NUM_W;
  localparam int unsigned DW = ilu_pkg::DIM_W;

  typedef enum logic {ST_RUN, ST_CLEAR} state_e;

  state_e st_q;
  logic [AW-1:0] clr_addr_q;
  logic [ilu_pkg::SIZE_W-1:0] last_q, size;

  logic [DW-1:0] width_q, height_q;
  logic [7:0] frame_top_q, trans_q, bg_q;
  logic restore_q;

  logic [CW-1:0] palette_mem [0:ilu_pkg::PAL_DEPTH-1];
  logic [CW-1:0] canvas_mem [0:ilu_pkg::CANVAS_DEPTH-1];
  logic [CW-1:0] pal_rd_q, cv_rd_q;

  logic [DW-1:0] w_eff, h_eff;
  logic [7:0] in_col, in_row, in_idx, rd_idx;
  logic [CW-1:0] in_color;
  logic in_fire, adv, mismatch, in_pixel, in_image;
  logic [AW-1:0] in_pos;

  logic s1_valid_q, fwd_q;
  logic [AW-1:0] s1_pos_q;
  logic [7:0] s1_col_q, s1_row_q;
  logic [CW-1:0] fwd_color_q, s1_cur;
  logic emit;

  logic cv_we;
  logic [AW-1:0] cv_wa;
  logic [CW-1:0] cv_wd;

  logic          dv_q    [0:QB];
  logic [CW-1:0] dcol_q  [0:QB];
  logic [NW-1:0] rem_q   [0:3][0:QB];
  logic [QB-1:0] quo_q   [0:3][0:QB];

  logic [8:0] rect_y;
  logic [7:0] rect_w, rect_h;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DW'(240);
      height_q    <= DW'(240);
      frame_top_q <= '0;
      restore_q   <= 1'b0;
      trans_q     <= '0;
      bg_q        <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ilu_pkg::CFG_IMAGE_WIDTH:       width_q     <= cfg_data_i;
        ilu_pkg::CFG_IMAGE_HEIGHT:      height_q    <= cfg_data_i;
        ilu_pkg::CFG_FRAME_TOP:         frame_top_q <= cfg_data_i[7:0];
        ilu_pkg::CFG_RESTORE_MODE:      restore_q   <= cfg_data_i[0];
        ilu_pkg::CFG_TRANSPARENT_INDEX: trans_q     <= cfg_data_i[7:0];
        ilu_pkg::CFG_BACKGROUND_INDEX:  bg_q        <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign w_eff    = ilu_pkg::clamp_dim(width_q);
  assign h_eff    = ilu_pkg::clamp_dim(height_q);
  assign size     = w_eff * h_eff;
  assign mismatch = size != last_q;

  assign in_col   = s_axis_tdata[7:0];
  assign in_row   = s_axis_tdata[15:8];
  assign in_idx   = s_axis_tdata[23:16];
  assign in_color = s_axis_tdata[39:24];
  assign in_pixel = s_axis_tuser == ilu_pkg::CMD_PIXEL;
  assign in_image = (DW'(in_col) < w_eff) && (DW'(in_row) < h_eff);
  assign rd_idx   = (restore_q && in_idx == trans_q) ? bg_q : in_idx;
  assign in_pos   = AW'(in_row) * AW'(w_eff) + AW'(in_col);

  assign adv           = !dv_q[QB] || m_axis_tready;
  assign s_axis_tready = adv && st_q == ST_RUN && !(in_pixel && mismatch);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_RUN;
      clr_addr_q <= '0;
      last_q     <= '0;
    end else begin
      unique case (st_q)
        ST_RUN: begin
          if (s_axis_tvalid && in_pixel && mismatch && !s1_valid_q) begin
            st_q       <= ST_CLEAR;
            clr_addr_q <= '0;
            last_q     <= size;
          end
        end
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == '1) st_q <= ST_RUN;
        end
        default: st_q <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !in_pixel) palette_mem[in_idx] <= in_color;
    if (adv) pal_rd_q <= palette_mem[rd_idx];
  end

  assign s1_cur = fwd_q ? fwd_color_q : cv_rd_q;
  assign emit   = s1_valid_q && (s1_cur != pal_rd_q);
  assign cv_we  = (st_q == ST_CLEAR) || (adv && emit);
  assign cv_wa  = (st_q == ST_CLEAR) ? clr_addr_q : s1_pos_q;
  assign cv_wd  = (st_q == ST_CLEAR) ? '0 : pal_rd_q;

  always_ff @(posedge clk_i) begin
    if (cv_we) canvas_mem[cv_wa] <= cv_wd;
    if (adv) cv_rd_q <= canvas_mem[in_pos];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_fire && in_pixel && in_image;
      fwd_q      <= emit && in_pos == s1_pos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pos_q    <= in_pos;
      s1_col_q    <= in_col;
      s1_row_q    <= in_row;
      fwd_color_q <= pal_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) dv_q[k] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= emit;
      for (int k = 0; k < QB; k++) dv_q[k+1] <= dv_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    ilu_pkg::div_step_t st;
    if (adv) begin
      dcol_q[0]   <= pal_rd_q;
      rem_q[0][0] <= NW'(17'(s1_col_q) * 17'(ilu_pkg::SCREEN_W));
      rem_q[1][0] <= NW'((17'(s1_col_q) + 17'd1) * 17'(ilu_pkg::SCREEN_W));
      rem_q[2][0] <= NW'(17'(s1_row_q) * 17'(ilu_pkg::SCREEN_H));
      rem_q[3][0] <= NW'((17'(s1_row_q) + 17'd1) * 17'(ilu_pkg::SCREEN_H));
      for (int j = 0; j < 4; j++) quo_q[j][0] <= '0;
      for (int k = 0; k < QB; k++) begin
        dcol_q[k+1] <= dcol_q[k];
        for (int j = 0; j < 4; j++) begin
          st = ilu_pkg::div_step(rem_q[j][k], (j < 2) ? w_eff : h_eff,
                                 QB - 1 - k);
          rem_q[j][k+1] <= st.rem;
          quo_q[j][k+1] <= {quo_q[j][k][QB-2:0], st.qbit};
        end
      end
    end
  end

  assign rect_y = 9'(frame_top_q) + 9'(quo_q[2][QB]);
  assign rect_w = quo_q[1][QB] - quo_q[0][QB];
  assign rect_h = quo_q[3][QB] - quo_q[2][QB];

  assign m_axis_tvalid = dv_q[QB];
  assign m_axis_tdata  = {7'd0, dcol_q[QB], rect_h, rect_w, rect_y, quo_q[0][QB]};

endmodule
`default_nettype wire

// ----- hdl/ilu_checker.sv -----
// Port-level checker for the upscaler and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module ilu_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [ilu_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [9:0] right_edge;
  assign right_edge = 10'(m_axis_tdata[7:0]) + 10'(m_axis_tdata[24:17]);

  `ASSERT_ALWAYS(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_NEVER(a_x_inside, clk_i, rst_ni, m_axis_tvalid && right_edge > 10'(ilu_pkg::SCREEN_W))
  `ASSERT_NEVER(a_h_bound, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[32:25] > 8'(ilu_pkg::SCREEN_H))

endmodule

bind indexed_line_upscale_dirty_rect ilu_checker u_ilu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- tb/sv/indexed_line_upscale_dirty_rect_tb.sv -----
// Self-checking testbench for the indexed-pixel upscaler with dirty-canvas rectangle output.
module indexed_line_upscale_dirty_rect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam logic [ilu_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [ilu_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [7:0]  x;
    logic [8:0]  y;
    logic [7:0]  wd;
    logic [7:0]  ht;
    logic [15:0] color;
  } rect_t;

  typedef struct {
    ilu_pkg::cmd_e cmd;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [7:0]  idx;
    logic [15:0] color;
    bit          typed;
    bit          has_rect;
    rect_t       rect;
  } stim_row_t;

  typedef struct {
    logic [8:0] w;
    logic [8:0] h;
    logic [7:0] top;
    logic       restore;
    logic [7:0] transp;
    logic [7:0] bg;
    int         items;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ilu_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ilu_pkg::DIM_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ilu_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ilu_pkg::M_TDATA_W-1:0] m_axis_tdata;

  indexed_line_upscale_dirty_rect dut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow state of the block.
  logic [15:0] palette_mem [ilu_pkg::PAL_DEPTH];
  logic [15:0] canvas_mem [ilu_pkg::CANVAS_DEPTH];
  logic [ilu_pkg::SIZE_W-1:0] canvas_size;
  logic [8:0] reg_w = 9'd240, reg_h = 9'd240;
  logic [7:0] reg_top = '0, reg_transp = '0, reg_bg = '0;
  logic reg_restore = 1'b0;

  rect_t pending_rects[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  function automatic logic [8:0] eff_dim(logic [8:0] v);
    if (v == 0) return 9'd1;
    if (v > 9'd256) return 9'd256;
    return v;
  endfunction

  task automatic draw_pixel(input ilu_pkg::cmd_e cmd, input logic [7:0] col,
                            input logic [7:0] row,
                            input logic [7:0] idx, input logic [15:0] color,
                            output bit hit, output rect_t r);
    int unsigned w, h, x0, x1, y0, y1, pos;
    logic [7:0] eidx;
    logic [15:0] c;
    hit = 0;
    r = '0;
    if (cmd == ilu_pkg::CMD_PALETTE) begin
      palette_mem[idx] = color;
      return;
    end
    w = eff_dim(reg_w);
    h = eff_dim(reg_h);
    if (ilu_pkg::SIZE_W'(w * h) != canvas_size) begin
      foreach (canvas_mem[i]) canvas_mem[i] = '0;
      canvas_size = ilu_pkg::SIZE_W'(w * h);
    end
    if (col >= w || row >= h) return;
    eidx = (reg_restore && idx == reg_transp) ? reg_bg : idx;
    c = palette_mem[eidx];
    pos = row * w + col;
    if (canvas_mem[pos] == c) return;
    canvas_mem[pos] = c;
    x0 = (col * ilu_pkg::SCREEN_W) / w;
    x1 = ((col + 1) * ilu_pkg::SCREEN_W) / w;
    y0 = (row * ilu_pkg::SCREEN_H) / h;
    y1 = ((row + 1) * ilu_pkg::SCREEN_H) / h;
    hit = 1;
    r.x = 8'(x0);
    r.y = 9'(reg_top + y0);
    r.wd = 8'(x1 - x0);
    r.ht = 8'(y1 - y0);
    r.color = c;
  endtask

  task automatic report(input string what, input rect_t exp_r, input rect_t got_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected x=%0d y=%0d w=%0d h=%0d c=%h, got x=%0d y=%0d w=%0d h=%0d c=%h",
               $time, what, exp_r.x, exp_r.y, exp_r.wd, exp_r.ht, exp_r.color,
               got_r.x, got_r.y, got_r.wd, got_r.ht, got_r.color);
  endtask

  task automatic send_word(input ilu_pkg::cmd_e cmd, input logic [7:0] col,
                           input logic [7:0] row,
                           input logic [7:0] idx, input logic [15:0] color,
                           output bit hit, output rect_t r);
    while (!steady && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = {color, idx, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    draw_pixel(cmd, col, row, idx, color, hit, r);
    if (hit) pending_rects.push_back(r);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [ilu_pkg::CFG_IDX_W-1:0] index,
                           input logic [8:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      ilu_pkg::CFG_IMAGE_WIDTH:       reg_w = value;
      ilu_pkg::CFG_IMAGE_HEIGHT:      reg_h = value;
      ilu_pkg::CFG_FRAME_TOP:         reg_top = value[7:0];
      ilu_pkg::CFG_RESTORE_MODE:      reg_restore = value[0];
      ilu_pkg::CFG_TRANSPARENT_INDEX: reg_transp = value[7:0];
      ilu_pkg::CFG_BACKGROUND_INDEX:  reg_bg = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(negedge clk_i)
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 38);

  always @(posedge clk_i) begin
    rect_t got, want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x     = m_axis_tdata[7:0];
      got.y     = m_axis_tdata[16:8];
      got.wd    = m_axis_tdata[24:17];
      got.ht    = m_axis_tdata[32:25];
      got.color = m_axis_tdata[48:33];
      if (pending_rects.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        want = pending_rects.pop_front();
        if (got !== want || m_axis_tdata[55:49] !== '0) report("word mismatch", want, got);
      end
    end
  end

  stim_row_t directed[$] = '{
    '{ilu_pkg::CMD_PALETTE, 8'd0, 8'd0, 8'h00, 16'hFFFF, 1, 0, '0},
    '{ilu_pkg::CMD_PALETTE, 8'd0, 8'd0, 8'hFF, 16'h0000, 1, 0, '0},
    '{ilu_pkg::CMD_PALETTE, 8'd0, 8'd0, 8'hAA, 16'hF800, 1, 0, '0},
    '{ilu_pkg::CMD_PALETTE, 8'd0, 8'd0, 8'h55, 16'h07E0, 1, 0, '0},
    '{ilu_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'h00, 16'h0000, 1, 1,
      '{8'd0, 9'd0, 8'd1, 8'd1, 16'hFFFF}},
    '{ilu_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'h00, 16'h0000, 1, 0, '0},
    '{ilu_pkg::CMD_PIXEL, 8'd239, 8'd239, 8'hAA, 16'hFFFF, 1, 1,
      '{8'd239, 9'd239, 8'd1, 8'd1, 16'hF800}},
    '{ilu_pkg::CMD_PIXEL, 8'd1, 8'd0, 8'hFF, 16'h0000, 1, 0, '0},
    '{ilu_pkg::CMD_PIXEL, 8'd240, 8'd0, 8'h00, 16'h0000, 1, 0, '0},
    '{ilu_pkg::CMD_PIXEL, 8'd0, 8'd240, 8'h00, 16'h0000, 1, 0, '0},
    '{ilu_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'h00, 16'hFFFF, 1, 0, '0},
    '{ilu_pkg::CMD_PALETTE, 8'd255, 8'd255, 8'h00, 16'h1234, 0, 0, '0},
    '{ilu_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'h00, 16'h0000, 1, 1,
      '{8'd0, 9'd0, 8'd1, 8'd1, 16'h1234}},
    '{ilu_pkg::CMD_PIXEL, 8'd5, 8'd7, 8'h55, 16'h0000, 1, 1,
      '{8'd5, 9'd7, 8'd1, 8'd1, 16'h07E0}},
    '{ilu_pkg::CMD_PIXEL, 8'd5, 8'd7, 8'h55, 16'h0000, 1, 0, '0},
    '{ilu_pkg::CMD_PIXEL, 8'd100, 8'd3, 8'hAA, 16'h0000, 0, 0, '0}
  };

  phase_t phases[$] = '{
    '{9'd256, 9'd256, 8'd239, 1'b1, 8'h0F, 8'hF0, 90},
    '{9'd16, 9'd8, 8'd0, 1'b1, 8'hFF, 8'h00, 60},
    '{9'd8, 9'd16, 8'd100, 1'b0, 8'h00, 8'hFF, 50},
    '{9'd0, 9'd300, 8'd17, 1'b1, 8'h80, 8'h01, 40},
    '{9'd511, 9'd1, 8'd0, 1'b0, 8'h01, 8'h80, 40},
    '{9'd1, 9'd1, 8'd239, 1'b1, 8'h05, 8'h05, 30},
    '{9'd200, 9'd150, 8'd37, 1'b1, 8'hAA, 8'h55, 70}
  };

  initial begin
    bit hit;
    rect_t r;
    int w, h, n;
    logic [7:0] col, row;
    foreach (palette_mem[i]) palette_mem[i] = '0;
    foreach (canvas_mem[i]) canvas_mem[i] = '0;
    canvas_size = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      send_word(directed[i].cmd, directed[i].col, directed[i].row, directed[i].idx,
                directed[i].color, hit, r);
      if (directed[i].typed && (hit != directed[i].has_rect || (hit && r != directed[i].rect)))
        report("directed row", directed[i].rect, r);
    end

    foreach (phases[p]) begin
      wait_drained();
      write_reg(ilu_pkg::CFG_IMAGE_WIDTH, phases[p].w);
      write_reg(ilu_pkg::CFG_IMAGE_HEIGHT, phases[p].h);
      write_reg(ilu_pkg::CFG_FRAME_TOP, phases[p].top);
      write_reg(ilu_pkg::CFG_RESTORE_MODE, phases[p].restore);
      write_reg(ilu_pkg::CFG_TRANSPARENT_INDEX, phases[p].transp);
      write_reg(ilu_pkg::CFG_BACKGROUND_INDEX, phases[p].bg);
      if (p == 1) begin
        write_reg(CFG_SPARE_LO, 9'($urandom));
        write_reg(CFG_SPARE_HI, 9'($urandom));
      end
      // Every palette entry is written once before random pixels may read it.
      if (p == 0)
        for (int i = 0; i < ilu_pkg::PAL_DEPTH; i++)
          send_word(ilu_pkg::CMD_PALETTE, 8'($urandom), 8'($urandom), 8'(i), 16'($urandom),
                    hit, r);
      w = eff_dim(phases[p].w);
      h = eff_dim(phases[p].h);
      for (n = 0; n < phases[p].items; n++) begin
        steady = (p == 0 && n >= 20 && n < 80);
        if (p == 2 && n == 40) wait_drained();
        if ($urandom_range(0, 99) < 25) begin
          send_word(ilu_pkg::CMD_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom), hit, r);
        end else begin
          col = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, w - 1)) : 8'($urandom);
          row = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, h - 1)) : 8'($urandom);
          send_word(ilu_pkg::CMD_PIXEL, col, row,
                    ($urandom_range(0, 3) == 0) ? phases[p].transp : 8'($urandom),
                    16'($urandom), hit, r);
        end
      end
      steady = 1'b0;
    end

    s_axis_tvalid = 1'b0;
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
